// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// needs clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gsa_pkg.sv =====
// types and constants of the generational slot allocator
// no dependencies
package gsa_pkg;

    localparam int SLOTS          = 256;
    localparam int SLOT_BITS      = 8;
    localparam int COUNT_BITS     = 9;
    localparam int GEN_BITS       = 16;
    localparam int ALBEDO_BITS    = 16;
    localparam int PAYLOAD_BITS   = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_UNLOAD = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_STALE     = 2'd2;
    localparam logic [1:0] STATUS_PROTECTED = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ENTRIES     = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_TEXTURE = 1'b1;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [SLOT_BITS-1:0]    slot_index;
        logic [GEN_BITS-1:0]     slot_generation;
        logic                    albedo_valid;
        logic [ALBEDO_BITS-1:0]  albedo_tex;
        logic [PAYLOAD_BITS-1:0] payload;
    } gsa_req_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]    result_index;
        logic [GEN_BITS-1:0]     result_generation;
        logic [1:0]              status;
        logic                    found;
        logic                    write_valid;
        logic [SLOT_BITS-1:0]    write_index;
        logic [ALBEDO_BITS-1:0]  write_albedo;
        logic [PAYLOAD_BITS-1:0] write_payload;
        logic [SLOT_BITS-1:0]    default_index;
        logic [GEN_BITS-1:0]     default_generation;
        logic                    default_valid;
    } gsa_rsp_t;

    typedef struct packed {
        logic     is_add;
        logic     is_unload;
        logic     is_update;
        gsa_req_t req;
    } gsa_cmd_t;

endpackage

// ===== rtl/gsa_front.sv =====
// front end: accepts request words, decodes them, queues them for the back end
// depends on gsa_pkg
module gsa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  gsa_pkg::gsa_req_t req,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output gsa_pkg::gsa_cmd_t cmd
);

    gsa_pkg::gsa_cmd_t q_mem [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push_ok;
    logic              take_ok;
    gsa_pkg::gsa_cmd_t dec;

    always_comb
    begin
        dec           = '0;
        dec.req       = req;
        case (req.req_type)
            gsa_pkg::REQ_ADD:    dec.is_add    = 1'b1;
            gsa_pkg::REQ_UNLOAD: dec.is_unload = 1'b1;
            gsa_pkg::REQ_UPDATE: dec.is_update = 1'b1;
            default:             dec.is_add    = 1'b0;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign push_ok   = push && !full;
    assign take_ok   = cmd_take && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ take_ok;
        count_next  = count_reg;
        if (push_ok && !take_ok)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take_ok && !push_ok)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/gsa_back.sv =====
// back end: handle table, free-slot stack, config registers and result register
// depends on gsa_pkg
module gsa_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_take,
    input  gsa_pkg::gsa_cmd_t                    cmd,
    output logic                                 empty,
    input  logic                                 pop,
    output gsa_pkg::gsa_rsp_t                    rsp,
    input  logic                                 cfg_we,
    input  logic [gsa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gsa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [gsa_pkg::GEN_BITS-1:0]   gen_mem   [gsa_pkg::SLOTS];
    logic [gsa_pkg::SLOT_BITS-1:0]  stack_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::GEN_BITS-1:0]   gen_rd_reg;
    logic [gsa_pkg::SLOT_BITS-1:0]  stack_rd_reg;
    logic                           gen_rd_en;
    logic [gsa_pkg::SLOT_BITS-1:0]  gen_rd_addr;
    logic                           gen_we;
    logic [gsa_pkg::SLOT_BITS-1:0]  gen_wr_addr;
    logic [gsa_pkg::GEN_BITS-1:0]   gen_wr_data;
    logic                           stack_we;
    logic [gsa_pkg::SLOT_BITS-1:0]  stack_wr_addr;
    logic [gsa_pkg::COUNT_BITS-1:0] free_depth_m1;

    gsa_pkg::gsa_cmd_t              cur_reg;
    logic [gsa_pkg::SLOTS-1:0]      live_reg, live_next;
    logic [gsa_pkg::COUNT_BITS-1:0] used_count_reg, used_count_next;
    logic [gsa_pkg::COUNT_BITS-1:0] free_depth_reg, free_depth_next;
    logic [gsa_pkg::SLOT_BITS-1:0]  dflt_index_reg, dflt_index_next;
    logic [gsa_pkg::GEN_BITS-1:0]   dflt_gen_reg, dflt_gen_next;
    logic                           dflt_set_reg, dflt_set_next;
    logic [gsa_pkg::COUNT_BITS-1:0] max_entries_reg;
    logic [gsa_pkg::ALBEDO_BITS-1:0] dflt_tex_reg;
    gsa_pkg::gsa_rsp_t              rsp_reg, rsp_next;
    logic                           rsp_valid_reg;

    logic                           exec_fire;
    logic                           fresh;
    logic                           add_full;
    logic                           hit;
    logic [gsa_pkg::COUNT_BITS-1:0] cap;
    logic [gsa_pkg::SLOT_BITS-1:0]  add_slot;
    logic [gsa_pkg::GEN_BITS-1:0]   add_gen;

    assign cmd_take      = (state_reg == ST_IDLE) && cmd_valid;
    assign exec_fire     = (state_reg == ST_EXEC) && (!rsp_valid_reg || pop);
    assign empty         = !rsp_valid_reg;
    assign rsp           = rsp_reg;
    assign free_depth_m1 = free_depth_reg - gsa_pkg::COUNT_BITS'(1);
    assign fresh         = (free_depth_reg == '0);
    assign cap           = (max_entries_reg > gsa_pkg::COUNT_BITS'(gsa_pkg::SLOTS))
                         ? gsa_pkg::COUNT_BITS'(gsa_pkg::SLOTS) : max_entries_reg;
    assign add_full      = fresh && (used_count_reg >= cap);
    assign hit           = ({1'b0, cur_reg.req.slot_index} < used_count_reg)
                         && live_reg[cur_reg.req.slot_index]
                         && (gen_rd_reg == cur_reg.req.slot_generation);

    // reuse of a freed slot needs a second generation read
    assign gen_rd_en   = cmd_take
                       || ((state_reg == ST_READ) && cur_reg.is_add && !fresh);
    assign gen_rd_addr = cmd_take ? cmd.req.slot_index : stack_rd_reg;

    always_ff @(posedge clk)
    begin
        if (gen_rd_en)
        begin
            gen_rd_reg <= gen_mem[gen_rd_addr];
        end
        if (gen_we)
        begin
            gen_mem[gen_wr_addr] <= gen_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            stack_rd_reg <= stack_mem[free_depth_m1[gsa_pkg::SLOT_BITS-1:0]];
        end
        if (stack_we)
        begin
            stack_mem[stack_wr_addr] <= cur_reg.req.slot_index;
        end
    end

    always_comb
    begin
        live_next       = live_reg;
        used_count_next = used_count_reg;
        free_depth_next = free_depth_reg;
        dflt_index_next = dflt_index_reg;
        dflt_gen_next   = dflt_gen_reg;
        dflt_set_next   = dflt_set_reg;
        gen_we          = 1'b0;
        gen_wr_addr     = cur_reg.req.slot_index;
        gen_wr_data     = gen_rd_reg + gsa_pkg::GEN_BITS'(1);
        stack_we        = 1'b0;
        stack_wr_addr   = free_depth_reg[gsa_pkg::SLOT_BITS-1:0];
        add_slot        = stack_rd_reg;
        add_gen         = gen_rd_reg;
        rsp_next        = '0;
        rsp_next.status = gsa_pkg::STATUS_OK;

        if (cur_reg.is_add)
        begin
            if (add_full)
            begin
                rsp_next.status            = gsa_pkg::STATUS_FULL;
                rsp_next.result_index      = dflt_index_reg;
                rsp_next.result_generation = dflt_gen_reg;
            end
            else
            begin
                if (fresh)
                begin
                    add_slot        = used_count_reg[gsa_pkg::SLOT_BITS-1:0];
                    add_gen         = '0;
                    used_count_next = used_count_reg + gsa_pkg::COUNT_BITS'(1);
                    gen_we          = 1'b1;
                    gen_wr_addr     = add_slot;
                    gen_wr_data     = '0;
                end
                else
                begin
                    free_depth_next = free_depth_m1;
                end
                live_next[add_slot]        = 1'b1;
                rsp_next.result_index      = add_slot;
                rsp_next.result_generation = add_gen;
                rsp_next.write_valid       = 1'b1;
                rsp_next.write_index       = add_slot;
                rsp_next.write_albedo      = cur_reg.req.albedo_valid
                                           ? cur_reg.req.albedo_tex : dflt_tex_reg;
                rsp_next.write_payload     = cur_reg.req.payload;
                if (!dflt_set_reg)
                begin
                    dflt_set_next   = 1'b1;
                    dflt_index_next = add_slot;
                    dflt_gen_next   = add_gen;
                end
            end
        end
        else
        begin
            rsp_next.found = hit;
            if (cur_reg.is_unload)
            begin
                if (!hit)
                begin
                    rsp_next.status = gsa_pkg::STATUS_STALE;
                end
                else if (dflt_set_reg && (cur_reg.req.slot_index == dflt_index_reg)
                         && (cur_reg.req.slot_generation == dflt_gen_reg))
                begin
                    rsp_next.status = gsa_pkg::STATUS_PROTECTED;
                end
                else
                begin
                    live_next[cur_reg.req.slot_index] = 1'b0;
                    gen_we = 1'b1;
                    if (free_depth_reg < gsa_pkg::COUNT_BITS'(gsa_pkg::SLOTS))
                    begin
                        stack_we        = 1'b1;
                        free_depth_next = free_depth_reg + gsa_pkg::COUNT_BITS'(1);
                    end
                end
            end
            else if (cur_reg.is_update)
            begin
                if (!hit)
                begin
                    rsp_next.status = gsa_pkg::STATUS_STALE;
                end
                else
                begin
                    rsp_next.write_valid   = 1'b1;
                    rsp_next.write_index   = cur_reg.req.slot_index;
                    rsp_next.write_albedo  = cur_reg.req.albedo_tex;
                    rsp_next.write_payload = cur_reg.req.payload;
                end
            end
        end

        rsp_next.default_index      = dflt_index_next;
        rsp_next.default_generation = dflt_gen_next;
        rsp_next.default_valid      = dflt_set_next;

        // memories change only when the result is committed
        if (!exec_fire)
        begin
            gen_we   = 1'b0;
            stack_we = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
        if (exec_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            live_reg        <= '0;
            used_count_reg  <= '0;
            free_depth_reg  <= '0;
            dflt_index_reg  <= '0;
            dflt_gen_reg    <= '0;
            dflt_set_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            max_entries_reg <= gsa_pkg::COUNT_BITS'(gsa_pkg::SLOTS);
            dflt_tex_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                live_reg       <= live_next;
                used_count_reg <= used_count_next;
                free_depth_reg <= free_depth_next;
                dflt_index_reg <= dflt_index_next;
                dflt_gen_reg   <= dflt_gen_next;
                dflt_set_reg   <= dflt_set_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (pop)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    gsa_pkg::CFG_MAX_ENTRIES:
                    begin
                        max_entries_reg <= cfg_data[gsa_pkg::COUNT_BITS-1:0];
                    end
                    gsa_pkg::CFG_DEFAULT_TEXTURE:
                    begin
                        dflt_tex_reg <= cfg_data;
                    end
                    default:
                    begin
                        dflt_tex_reg <= dflt_tex_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/generational_slot_allocator.sv =====
// generational slot allocator top level: handle table for material slots
// usage notes below; depends on gsa_pkg, gsa_front, gsa_back, assert_macros.svh
//
// request words enter through a queue-style port: a word is taken at a clock
// edge with push high and full low. result words leave the same way: while
// empty is low the oldest result is on rsp, and pop high takes it.
// every request gives exactly one result word, in request order.
// a two-entry queue sits between the front end and the back end, so the
// input keeps taking words while a result waits.
// the back end takes no new request until the last one is committed: it runs
// a read/read/commit sequence on the generation memory and free-slot stack.
// when the receiver holds off pop, the back end stalls in its commit step and
// the input queue fills, then full rises.
// reset empties both queues, clears all live bits, counts and the default
// handle, and sets max_entries to 256 and default_texture_index to 0.
// config writes (cfg_we, cfg_index, cfg_data) take effect the next cycle and
// are meant to happen while no request is in flight.
`include "assert_macros.svh"

module generational_slot_allocator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  gsa_pkg::gsa_req_t                    req,
    output logic                                 empty,
    input  logic                                 pop,
    output gsa_pkg::gsa_rsp_t                    rsp,
    input  logic                                 cfg_we,
    input  logic [gsa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gsa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic              cmd_valid;
    logic              cmd_take;
    gsa_pkg::gsa_cmd_t cmd;

    gsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    gsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    `ASSERT_IMPLIES(a_write_only_ok, !empty && rsp.write_valid,
        rsp.status == gsa_pkg::STATUS_OK)
    `ASSERT_IMPLIES(a_full_gives_default, !empty && (rsp.status == gsa_pkg::STATUS_FULL),
        !rsp.write_valid && (rsp.result_index == rsp.default_index)
        && (rsp.result_generation == rsp.default_generation))
    `ASSERT_IMPLIES(a_stale_no_effect, !empty && (rsp.status == gsa_pkg::STATUS_STALE),
        !rsp.found && !rsp.write_valid)
    `ASSERT_NEXT(a_default_sticks, !empty && rsp.default_valid && pop, empty || rsp.default_valid)

endmodule
